[hw/rtl/cmrh_pkg.sv]
// ----------------------------------------------------------------------------
// cmrh_pkg
// Shared types, register indexes, reset values and constant dividers for the
// column motor ramp and homing controller.
// ----------------------------------------------------------------------------
package cmrh_pkg;

    localparam int unsigned SpeedW   = 8;
    localparam int unsigned CurrentW = 10;
    localparam int unsigned RefW     = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [SpeedW-1:0]   SpeedReset   = 8'd250;
    localparam logic [CurrentW-1:0] LimitReset   = 10'd135;
    localparam logic [RefW-1:0]     RefTickReset = 16'd50;
    localparam logic [SpeedW-1:0]   DutyMax      = 8'd255;

    localparam logic [CfgIdxW-1:0] REG_TARGET_SPEED    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CURRENT_LIMIT   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_REFERENCE_TICKS = 2'd2;

    typedef enum logic [1:0] {
        CMD_LIFT      = 2'd0,
        CMD_RETRACT   = 2'd1,
        CMD_REFERENCE = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [SpeedW-1:0]   lift_step;
        logic [SpeedW-1:0]   lift_top;
        logic [SpeedW-1:0]   ret_step;
        logic [SpeedW-1:0]   ret_top;
        logic [CurrentW-1:0] current_limit;
    } t_cfg;

    typedef struct packed {
        logic            load;
        logic [RefW-1:0] value;
    } t_ref_load;

    // Exact constant division of an 8-bit value by reciprocal multiplication.
    function automatic logic [SpeedW-1:0] div_const(input logic [SpeedW-1:0] x,
                                                    input logic [8:0] mul,
                                                    input logic [3:0] shift);
        logic [17:0] p;
        p = 18'(x) * 18'(mul);
        return SpeedW'(p >> shift);
    endfunction

    function automatic logic [SpeedW-1:0] div9(input logic [SpeedW-1:0] x);
        return div_const(x, 9'd57, 4'd9);
    endfunction

    function automatic logic [SpeedW-1:0] div10(input logic [SpeedW-1:0] x);
        return div_const(x, 9'd205, 4'd11);
    endfunction

    function automatic logic [SpeedW-1:0] div20(input logic [SpeedW-1:0] x);
        return div_const(x, 9'd205, 4'd12);
    endfunction

    function automatic logic [SpeedW-1:0] div21(input logic [SpeedW-1:0] x);
        return div_const(x, 9'd391, 4'd13);
    endfunction

    function automatic logic [SpeedW-1:0] sat_add(input logic [SpeedW-1:0] a,
                                                  input logic [SpeedW-1:0] b);
        logic [SpeedW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SpeedW] ? DutyMax : s[SpeedW-1:0];
    endfunction

endpackage

[hw/rtl/cmrh_in_if.sv]
// ----------------------------------------------------------------------------
// cmrh_in_if
// Tick channel: command, sampled motor current and lower endstop level.
// ----------------------------------------------------------------------------
interface cmrh_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [cmrh_pkg::CurrentW-1:0] motor_current;
    logic                          at_endstop;

    modport source (output valid, output cmd, output motor_current, output at_endstop,
                    input ready);
    modport sink   (input valid, input cmd, input motor_current, input at_endstop,
                    output ready);
endinterface

[hw/rtl/cmrh_out_if.sv]
// ----------------------------------------------------------------------------
// cmrh_out_if
// Result channel: both duties after the tick and the done flag.
// ----------------------------------------------------------------------------
interface cmrh_out_if;
    logic                        valid;
    logic                        ready;
    logic [cmrh_pkg::SpeedW-1:0] up_duty;
    logic [cmrh_pkg::SpeedW-1:0] down_duty;
    logic                        done_res;

    modport source (output valid, output up_duty, output down_duty, output done_res,
                    input ready);
    modport sink   (input valid, input up_duty, input down_duty, input done_res,
                    output ready);
endinterface

[hw/rtl/cmrh_cfg.sv]
// ----------------------------------------------------------------------------
// cmrh_cfg
// Configuration registers. Ramp steps and ramp end levels are derived from the
// target speed when it is written.
// ----------------------------------------------------------------------------
module cmrh_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cmrh_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [cmrh_pkg::CfgDataW-1:0] i_cfg_data,
    output cmrh_pkg::t_cfg                o_cfg,
    output cmrh_pkg::t_ref_load           o_ref_load
);

    logic [cmrh_pkg::SpeedW-1:0]   w_speed;
    logic [cmrh_pkg::SpeedW-1:0]   r_lift_step;
    logic [cmrh_pkg::SpeedW-1:0]   r_lift_top;
    logic [cmrh_pkg::SpeedW-1:0]   r_ret_step;
    logic [cmrh_pkg::SpeedW-1:0]   r_ret_top;
    logic [cmrh_pkg::CurrentW-1:0] r_limit;

    assign w_speed = i_cfg_data[cmrh_pkg::SpeedW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lift_step <= cmrh_pkg::div9(cmrh_pkg::SpeedReset);
            r_lift_top  <= cmrh_pkg::SpeedReset - cmrh_pkg::div10(cmrh_pkg::SpeedReset);
            r_ret_step  <= cmrh_pkg::div20(cmrh_pkg::SpeedReset);
            r_ret_top   <= cmrh_pkg::SpeedReset - cmrh_pkg::div21(cmrh_pkg::SpeedReset);
            r_limit     <= cmrh_pkg::LimitReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmrh_pkg::REG_TARGET_SPEED: begin
                    r_lift_step <= cmrh_pkg::div9(w_speed);
                    r_lift_top  <= w_speed - cmrh_pkg::div10(w_speed);
                    r_ret_step  <= cmrh_pkg::div20(w_speed);
                    r_ret_top   <= w_speed - cmrh_pkg::div21(w_speed);
                end
                cmrh_pkg::REG_CURRENT_LIMIT: begin
                    r_limit <= i_cfg_data[cmrh_pkg::CurrentW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.lift_step     = r_lift_step;
    assign o_cfg.lift_top      = r_lift_top;
    assign o_cfg.ret_step      = r_ret_step;
    assign o_cfg.ret_top       = r_ret_top;
    assign o_cfg.current_limit = r_limit;

    assign o_ref_load.load  = i_cfg_we && (i_cfg_idx == cmrh_pkg::REG_REFERENCE_TICKS);
    assign o_ref_load.value = i_cfg_data[cmrh_pkg::RefW-1:0];

endmodule

[hw/rtl/cmrh_tick.sv]
// ----------------------------------------------------------------------------
// cmrh_tick
// Next-state logic of one control tick: lift ramp with current stop, retract
// ramp with endstop stop, and the reference run sequence.
// ----------------------------------------------------------------------------
module cmrh_tick (
    input  logic [1:0]                    i_cmd,
    input  logic [cmrh_pkg::CurrentW-1:0] i_current,
    input  logic                          i_endstop,
    input  logic [cmrh_pkg::SpeedW-1:0]   i_raise,
    input  logic [cmrh_pkg::SpeedW-1:0]   i_lower,
    input  logic [cmrh_pkg::RefW-1:0]     i_ref_left,
    input  cmrh_pkg::t_cfg                i_cfg,
    output logic [cmrh_pkg::SpeedW-1:0]   o_raise,
    output logic [cmrh_pkg::SpeedW-1:0]   o_lower,
    output logic [cmrh_pkg::RefW-1:0]     o_ref_left,
    output logic                          o_done
);

    logic [cmrh_pkg::SpeedW-1:0] w_lift_raise;
    logic                        w_lift_done;
    logic [cmrh_pkg::SpeedW-1:0] w_ret_lower;
    logic                        w_ret_done;

    always_comb begin
        w_lift_raise = i_raise;
        w_lift_done  = 1'b0;
        if (i_raise < i_cfg.lift_top) begin
            w_lift_raise = cmrh_pkg::sat_add(i_raise, i_cfg.lift_step);
        end else if (i_current > i_cfg.current_limit) begin
            w_lift_raise = '0;
            w_lift_done  = 1'b1;
        end
    end

    always_comb begin
        w_ret_lower = i_lower;
        w_ret_done  = 1'b0;
        if (i_endstop) begin
            w_ret_lower = '0;
            w_ret_done  = 1'b1;
        end else if (i_lower < i_cfg.ret_top) begin
            w_ret_lower = cmrh_pkg::sat_add(i_lower, i_cfg.ret_step);
        end
    end

    always_comb begin
        o_raise    = i_raise;
        o_lower    = i_lower;
        o_ref_left = i_ref_left;
        o_done     = 1'b0;
        case (cmrh_pkg::t_cmd'(i_cmd))
            cmrh_pkg::CMD_LIFT: begin
                o_raise = w_lift_raise;
                o_done  = w_lift_done;
            end
            cmrh_pkg::CMD_RETRACT: begin
                o_lower = w_ret_lower;
                o_done  = w_ret_done;
            end
            cmrh_pkg::CMD_REFERENCE: begin
                // The lift phase of a reference run never reports done.
                if (i_ref_left != '0) begin
                    o_raise    = w_lift_raise;
                    o_ref_left = i_ref_left - cmrh_pkg::RefW'(1);
                end else if (i_raise == '0) begin
                    o_lower = w_ret_lower;
                    o_done  = w_ret_done;
                end else begin
                    o_raise = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/column_motor_ramp_homing.sv]
// ----------------------------------------------------------------------------
// column_motor_ramp_homing
// Soft-start PWM ramp for a lifting column motor with current limit and a
// reference run.
// ----------------------------------------------------------------------------
// One tick word is accepted every clock cycle unless a stalled result word
// holds the input register: the word is captured in an input register, the
// tick logic updates the duty and counter state, and the result is held in an
// output register until it is taken. The duties on the result port are the
// state registers themselves. Configuration writes take effect on the next
// cycle; writing reference_ticks also reloads the reference run counter.
module column_motor_ramp_homing (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cmrh_in_if.sink                       i_in_ch,
    cmrh_out_if.source                    o_out_ch,
    input  logic                          i_cfg_we,
    input  logic [cmrh_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [cmrh_pkg::CfgDataW-1:0] i_cfg_data
);

    cmrh_pkg::t_cfg      w_cfg;
    cmrh_pkg::t_ref_load w_ref_load;

    logic                          r_in_valid;
    logic [1:0]                    r_cmd;
    logic [cmrh_pkg::CurrentW-1:0] r_current;
    logic                          r_endstop;

    logic                          r_out_valid;
    logic                          r_done;
    logic [cmrh_pkg::SpeedW-1:0]   r_raise;
    logic [cmrh_pkg::SpeedW-1:0]   r_lower;
    logic [cmrh_pkg::RefW-1:0]     r_ref_left;

    logic [cmrh_pkg::SpeedW-1:0]   n_raise;
    logic [cmrh_pkg::SpeedW-1:0]   n_lower;
    logic [cmrh_pkg::RefW-1:0]     n_ref_left;
    logic                          n_done;

    logic                          w_advance;
    logic                          w_in_ready;

    cmrh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_ref_load (w_ref_load)
    );

    cmrh_tick u_tick (
        .i_cmd      (r_cmd),
        .i_current  (r_current),
        .i_endstop  (r_endstop),
        .i_raise    (r_raise),
        .i_lower    (r_lower),
        .i_ref_left (r_ref_left),
        .i_cfg      (w_cfg),
        .o_raise    (n_raise),
        .o_lower    (n_lower),
        .o_ref_left (n_ref_left),
        .o_done     (n_done)
    );

    assign w_advance  = !r_out_valid || o_out_ch.ready;
    assign w_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_raise     <= '0;
            r_lower     <= '0;
            r_ref_left  <= cmrh_pkg::RefTickReset;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in_ch.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_advance && r_in_valid) begin
                r_raise    <= n_raise;
                r_lower    <= n_lower;
            end
            if (w_ref_load.load) begin
                r_ref_left <= w_ref_load.value;
            end else if (w_advance && r_in_valid) begin
                r_ref_left <= n_ref_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_ch.valid) begin
            r_cmd     <= i_in_ch.cmd;
            r_current <= i_in_ch.motor_current;
            r_endstop <= i_in_ch.at_endstop;
        end
        if (w_advance && r_in_valid) begin
            r_done <= n_done;
        end
    end

    assign i_in_ch.ready      = w_in_ready;
    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.up_duty   = r_raise;
    assign o_out_ch.down_duty = r_lower;
    assign o_out_ch.done_res  = r_done;

endmodule

[hw/rtl/cmrh_checker.sv]
// ----------------------------------------------------------------------------
// cmrh_checker
// Port-level checks of the column motor controller, bound to the top level.
// ----------------------------------------------------------------------------
module cmrh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cmrh_pkg::SpeedW-1:0] i_up_duty,
    input logic [cmrh_pkg::SpeedW-1:0] i_down_duty,
    input logic                        i_done_res
);

    // A stalled result word keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_up_duty) && $stable(i_down_duty)
             && $stable(i_done_res)))
        else $error("stalled result word changed");

    // A finished motion always leaves the stopped direction at zero duty.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |-> (i_up_duty == '0 || i_down_duty == '0))
        else $error("done reported with both duties nonzero");

    // With the result register empty the input side can never stall.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while result register empty");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

endmodule

bind column_motor_ramp_homing cmrh_checker u_cmrh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_up_duty   (o_out_ch.up_duty),
    .i_down_duty (o_out_ch.down_duty),
    .i_done_res  (o_out_ch.done_res)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column motor ramp and homing controller. Tick
// words are fed in random bursts while the result port stalls on a shifting
// pattern. A built-in predictor of the duty ramps, the current stop and the
// reference run checks every result word in order, across several register
// settings written between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import cmrh_pkg::*;

    localparam logic [1:0]         CMD_HOLD  = 2'd3;
    localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
    localparam int unsigned        TimeoutNs = 5_000_000;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [CurrentW-1:0] current;
        logic                endstop;
    } column_tick_t;

    typedef struct packed {
        logic [SpeedW-1:0] up;
        logic [SpeedW-1:0] down;
        logic              done;
    } duty_report_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    cmrh_in_if  tick_ch ();
    cmrh_out_if report_ch ();

    column_motor_ramp_homing dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_ch    (tick_ch),
        .o_out_ch   (report_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    column_tick_t pending_ticks[$];
    duty_report_t expected_reports[$];
    column_tick_t next_tick;
    duty_report_t oldest_report;
    int unsigned  fail_count = 0;

    logic [SpeedW-1:0]   speed_set;
    logic [CurrentW-1:0] limit_set;
    logic [SpeedW-1:0]   model_up;
    logic [SpeedW-1:0]   model_down;
    logic [RefW-1:0]     homing_left;

    logic        tick_taken  = 1'b0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    logic [7:0]  ready_mask  = 8'hFF;
    logic [2:0]  ready_phase = '0;

    always #6 clk = ~clk;

    function automatic logic [SpeedW-1:0] duty_add(input logic [SpeedW-1:0] a,
                                                   input logic [SpeedW-1:0] b);
        int unsigned s;
        s = a + b;
        return (s > 255) ? 8'hFF : s[SpeedW-1:0];
    endfunction

    function automatic logic lift_step(input logic [CurrentW-1:0] current);
        if (model_up < speed_set - speed_set / 10) begin
            model_up = duty_add(model_up, speed_set / 9);
            return 1'b0;
        end
        if (current > limit_set) begin
            model_up = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic retract_step(input logic endstop);
        if (endstop) begin
            model_down = '0;
            return 1'b1;
        end
        if (model_down < speed_set - speed_set / 21)
            model_down = duty_add(model_down, speed_set / 20);
        return 1'b0;
    endfunction

    function automatic duty_report_t advance_column(input column_tick_t t);
        logic done;
        done = 1'b0;
        case (t.cmd)
            CMD_LIFT: done = lift_step(t.current);
            CMD_RETRACT: done = retract_step(t.endstop);
            CMD_REFERENCE: begin
                // The lift done flag is dropped while the homing counter runs.
                if (homing_left != '0) begin
                    void'(lift_step(t.current));
                    homing_left = homing_left - 1'b1;
                end else if (model_up == '0) begin
                    done = retract_step(t.endstop);
                end else begin
                    model_up = '0;
                end
            end
            default: ;
        endcase
        return '{up: model_up, down: model_down, done: done};
    endfunction

    task automatic queue_tick(input logic [1:0] op, input int unsigned amps, input logic at_end);
        pending_ticks.push_back('{cmd: op, current: amps[CurrentW-1:0], endstop: at_end});
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                  input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_TARGET_SPEED: speed_set = data[SpeedW-1:0];
            REG_CURRENT_LIMIT: limit_set = data[CurrentW-1:0];
            REG_REFERENCE_TICKS: homing_left = data[RefW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(posedge clk);
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly complete motions (ramp then stop, ramp then endstop, homing run)
    // with random content, mixed with loose noise words.
    task automatic queue_motion_mix(input int unsigned count);
        int unsigned added;
        int unsigned n;
        added = 0;
        while (added < count) begin
            n = $urandom_range(1, 12);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat (n) queue_tick(CMD_LIFT, $urandom_range(0, limit_set), 1'($urandom));
                    queue_tick(CMD_LIFT,
                               (limit_set == '1) ? 1023 : $urandom_range(limit_set + 1, 1023),
                               1'($urandom));
                    added += n + 1;
                end
                3, 4, 5: begin
                    repeat (n) queue_tick(CMD_RETRACT, $urandom_range(0, 1023), 1'b0);
                    queue_tick(CMD_RETRACT, $urandom_range(0, 1023), 1'b1);
                    added += n + 1;
                end
                6, 7: begin
                    n = $urandom_range(1, 20);
                    repeat (n) queue_tick(CMD_REFERENCE, $urandom_range(0, 1023), 1'b0);
                    queue_tick(CMD_REFERENCE, $urandom_range(0, 1023), 1'b1);
                    added += n + 1;
                end
                8: begin
                    repeat (n) queue_tick($urandom_range(0, 3), $urandom_range(0, 1023),
                                          1'($urandom));
                    added += n;
                end
                default: begin
                    queue_tick(CMD_HOLD, $urandom_range(0, 1023), 1'($urandom));
                    added += 1;
                end
            endcase
        end
    endtask

    // The sender stops halfway until every result word is back.
    task automatic run_phase(input logic [SpeedW-1:0] speed, input logic [CurrentW-1:0] limit,
                             input logic [RefW-1:0] ticks, input int unsigned count);
        settle();
        write_register(REG_TARGET_SPEED, {8'($urandom), speed});
        write_register(REG_CURRENT_LIMIT, {6'($urandom), limit});
        write_register(REG_REFERENCE_TICKS, ticks);
        queue_motion_mix(count / 2);
        settle();
        queue_motion_mix(count - count / 2);
    endtask

    always @(negedge clk) begin
        if (!tick_ch.valid || tick_taken) begin
            if (gap_left != 0) begin
                tick_ch.valid <= 1'b0;
                gap_left      <= gap_left - 1;
            end else if (pending_ticks.size() != 0) begin
                next_tick = pending_ticks.pop_front();
                tick_ch.valid         <= 1'b1;
                tick_ch.cmd           <= next_tick.cmd;
                tick_ch.motor_current <= next_tick.current;
                tick_ch.at_endstop    <= next_tick.endstop;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (ready_phase == '1) begin
            ready_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        end
        ready_phase     <= ready_phase + 1'b1;
        report_ch.ready <= ready_mask[ready_phase];
    end

    always @(posedge clk) begin
        tick_taken <= tick_ch.valid && tick_ch.ready;
        if (rst_n) begin
            if (report_ch.valid && report_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result word: up_duty %0d down_duty %0d done_res %0d",
                           report_ch.up_duty, report_ch.down_duty, report_ch.done_res);
                    fail_count++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    if (report_ch.up_duty !== oldest_report.up) begin
                        $error("up_duty: expected %0d, got %0d",
                               oldest_report.up, report_ch.up_duty);
                        fail_count++;
                    end
                    if (report_ch.down_duty !== oldest_report.down) begin
                        $error("down_duty: expected %0d, got %0d",
                               oldest_report.down, report_ch.down_duty);
                        fail_count++;
                    end
                    if (report_ch.done_res !== oldest_report.done) begin
                        $error("done_res: expected %0d, got %0d",
                               oldest_report.done, report_ch.done_res);
                        fail_count++;
                    end
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                expected_reports.push_back(advance_column('{cmd: tick_ch.cmd,
                                                           current: tick_ch.motor_current,
                                                           endstop: tick_ch.at_endstop}));
            end
        end
    end

    initial begin
        tick_ch.valid         = 1'b0;
        tick_ch.cmd           = CMD_LIFT;
        tick_ch.motor_current = '0;
        tick_ch.at_endstop    = 1'b0;
        report_ch.ready       = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = REG_TARGET_SPEED;
        cfg_data              = '0;
        rst_n                 = 1'b0;
        speed_set             = SpeedReset;
        limit_set             = LimitReset;
        homing_left           = RefTickReset;
        model_up              = '0;
        model_down            = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_tick(CMD_LIFT, 0, 1'b0);
        queue_tick(CMD_LIFT, 0, 1'b1);
        queue_tick(CMD_LIFT, 1023, 1'b0);
        queue_tick(CMD_HOLD, 1023, 1'b1);
        queue_tick(CMD_RETRACT, 0, 1'b0);
        queue_tick(CMD_RETRACT, 0, 1'b0);
        queue_tick(CMD_RETRACT, 512, 1'b1);
        queue_tick(CMD_REFERENCE, 1023, 1'b1);
        queue_tick(CMD_HOLD, 0, 1'b0);

        // With zero speed the ramp is already finished, so a high current stops the lift.
        settle();
        write_register(REG_TARGET_SPEED, 16'd0);
        queue_tick(CMD_LIFT, 1023, 1'b0);

        // Ramp to 200 at one speed, then past 255 at a faster one to saturate.
        settle();
        write_register(REG_TARGET_SPEED, 16'd225);
        repeat (8) queue_tick(CMD_LIFT, 0, 1'b0);
        settle();
        write_register(REG_TARGET_SPEED, 16'd255);
        write_register(REG_REFERENCE_TICKS, 16'd2);
        write_register(REG_SPARE, 16'hFFFF);
        queue_tick(CMD_LIFT, 0, 1'b0);
        queue_tick(CMD_LIFT, 0, 1'b0);
        queue_tick(CMD_LIFT, 1023, 1'b0);
        queue_tick(CMD_REFERENCE, 1023, 1'b0);
        queue_tick(CMD_REFERENCE, 0, 1'b0);
        queue_tick(CMD_REFERENCE, 0, 1'b0);
        queue_tick(CMD_REFERENCE, 0, 1'b0);
        queue_tick(CMD_REFERENCE, 0, 1'b1);

        run_phase(8'd250, 10'd135, 16'd5, 90);
        run_phase(8'd255, 10'd1023, 16'hFFFF, 80);
        run_phase(8'd0, 10'd0, 16'd0, 70);
        run_phase(8'($urandom), 10'($urandom), 16'($urandom_range(0, 30)), 90);
        run_phase(8'd1, 10'd1, 16'd1, 60);
        run_phase(8'($urandom_range(200, 255)), 10'($urandom), 16'($urandom_range(1, 12)), 110);
        settle();

        if (fail_count == 0) begin
            $display("column_motor_ramp_homing test passed");
        end else begin
            $display("column_motor_ramp_homing test failed");
        end
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("column_motor_ramp_homing test failed");
        $finish;
    end

endmodule
